// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int SPQ_DEPTH  = 16;
    localparam int KEY_BITS   = 8;
    localparam int TAG_BITS   = 16;
    localparam int LIMIT_BITS = 5;
    localparam int OCC_BITS   = 5;
    localparam int STAT_BITS  = 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_POPPED   = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                op;
        logic [KEY_BITS-1:0] urgency_level;
        logic [TAG_BITS-1:0] entry_tag;
    } spq_in_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [KEY_BITS-1:0]  popped_urgency;
        logic [TAG_BITS-1:0]  popped_tag;
        logic [OCC_BITS-1:0]  occupancy;
    } spq_out_t;

    typedef struct packed {
        logic                ins;
        logic                pop;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } spq_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell (
    input  logic                         clk,
    input  spq_pkg::spq_ctrl_t           ctrl,
    input  logic                         occupied,
    input  logic                         left_ge,
    input  logic [spq_pkg::KEY_BITS-1:0] left_key,
    input  logic [spq_pkg::TAG_BITS-1:0] left_tag,
    input  logic [spq_pkg::KEY_BITS-1:0] right_key,
    input  logic [spq_pkg::TAG_BITS-1:0] right_tag,
    output logic                         ge,
    output logic [spq_pkg::KEY_BITS-1:0] key,
    output logic [spq_pkg::TAG_BITS-1:0] tag
);
    import spq_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // An occupied cell whose key is at least the new key keeps its entry.
    assign ge = occupied && (key_reg >= ctrl.key);

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.ins && !ge)
        begin
            if (left_ge)
            begin
                key_next = ctrl.key;
                tag_next = ctrl.tag;
            end
            else
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
// Sorted priority queue of urgency keys with tags, front entry is the most urgent.
// Command channel: drive cmd and raise start; the word is taken at a rising edge
// with start high and busy low. Busy stays low, so a word can be taken every cycle.
// Each word gives exactly one result word on result, marked by done for one cycle,
// in the cycle after the command is taken. The receiver cannot stall the result.
// An insert places the entry after all entries of equal or higher urgency.
// An insert at the capacity limit is refused with status full, a pop on an empty
// queue is refused with status empty; popped fields are zero unless popped.
// Throughput is one word per cycle, set by the row of cells that all compare
// against the new key and shift in the same cycle. The user must write the
// capacity limit via cfg_we/cfg_wdata only while idle; the block does not check.
// Reset empties the queue and sets the capacity limit to sixteen.
module sorted_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  spq_pkg::spq_in_t               cmd,
    input  logic                           cfg_we,
    input  logic [spq_pkg::LIMIT_BITS-1:0] cfg_wdata,
    output logic                           done,
    output spq_pkg::spq_out_t              result
);
    import spq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic                  done_reg;
    spq_out_t              result_reg;
    spq_out_t              result_next;
    spq_ctrl_t             ctrl;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [CMP_BITS-1:0]   count_wide;

    logic [DEPTH-1:0]    cell_ge;
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (CMP_BITS'(count_reg) >= CMP_BITS'(limit_reg))
                || (count_reg >= CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctrl.ins = accept && (cmd.op == OP_INSERT) && !full;
        ctrl.pop = accept && (cmd.op == OP_POP) && !empty;
        ctrl.key = cmd.urgency_level;
        ctrl.tag = cmd.entry_tag;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    assign count_wide = CMP_BITS'(count_next);

    always_comb
    begin
        result_next.popped_urgency = '0;
        result_next.popped_tag     = '0;
        result_next.occupancy      = count_wide[OCC_BITS-1:0];
        if (cmd.op == OP_INSERT)
        begin
            result_next.status = full ? ST_FULL : ST_INSERTED;
        end
        else if (empty)
        begin
            result_next.status = ST_EMPTY;
        end
        else
        begin
            result_next.status         = ST_POPPED;
            result_next.popped_urgency = cell_key[0];
            result_next.popped_tag     = cell_tag[0];
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                occ;
            logic                lge;
            logic [KEY_BITS-1:0] lkey;
            logic [TAG_BITS-1:0] ltag;
            logic [KEY_BITS-1:0] rkey;
            logic [TAG_BITS-1:0] rtag;

            assign occ = (count_reg > CNT_BITS'(i));

            if (i == 0)
            begin : g_first
                assign lge  = 1'b1;
                assign lkey = ctrl.key;
                assign ltag = ctrl.tag;
            end
            else
            begin : g_mid
                assign lge  = cell_ge[i-1];
                assign lkey = cell_key[i-1];
                assign ltag = cell_tag[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign rkey = cell_key[i];
                assign rtag = cell_tag[i];
            end
            else
            begin : g_inner
                assign rkey = cell_key[i+1];
                assign rtag = cell_tag[i+1];
            end

            spq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (occ),
                .left_ge   (lge),
                .left_key  (lkey),
                .left_tag  (ltag),
                .right_key (rkey),
                .right_tag (rtag),
                .ge        (cell_ge[i]),
                .key       (cell_key[i]),
                .tag       (cell_tag[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/spq_checker.sv -----
module spq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input spq_pkg::spq_in_t  cmd,
    input logic              done,
    input spq_pkg::spq_out_t result
);
    import spq_pkg::*;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("Accepted word did not give a result word.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("Result word without an accepted command.");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_POPPED)
            |-> (result.popped_urgency == '0 && result.popped_tag == '0))
        else $error("Popped fields not zero without a pop.");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> (result.occupancy == '0))
        else $error("Empty pop reported nonzero occupancy.");

    a_status_op: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_INSERT)
            |=> (result.status == ST_INSERTED || result.status == ST_FULL))
        else $error("Insert gave a pop status.");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
